FILE: rtl/core/rxr_pkg.sv
package rxr_pkg;

  localparam int FRAC_BITS = 16;
  localparam int CW = 32;
  // Magnitude of (plane_z - origin_z) scaled by the fraction bits.
  localparam int DIV_W = CW + FRAC_BITS;
  // Full-precision hit coordinate: origin plus floor(t * dir / 2^FRAC_BITS).
  localparam int PX_W = 2 * CW - FRAC_BITS + 1;
  localparam int UV_BITS = 16;
  localparam int UVQ_W = UV_BITS + 1;
  localparam int UV_LAT = UVQ_W + 1;
  localparam int CFG_IW = 3;

  typedef enum logic [CFG_IW-1:0] {
    REG_X_LOW    = 3'd0,
    REG_X_HIGH   = 3'd1,
    REG_Y_LOW    = 3'd2,
    REG_Y_HIGH   = 3'd3,
    REG_PLANE_Z  = 3'd4,
    REG_MATERIAL = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [CW-1:0] ox;
    logic signed [CW-1:0] oy;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [CW-1:0] tmin;
    logic signed [CW-1:0] tmax;
    logic                 dzneg;
    logic                 neg;
    logic                 zero;
  } ray_side_t;

  typedef struct packed {
    logic                 hit;
    logic                 dzneg;
    logic signed [CW-1:0] t;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
  } uv_side_t;

endpackage

FILE: rtl/core/ray_xy_rect_intersect.sv
// Ray against a rectangle lying in a plane of constant z.
// Input channel: one ray per beat (origin, direction, t_min/t_max), taken
// when in_valid is high and in_stall is low. Output channel: one result beat
// per ray, taken when out_valid is high and out_stall is low. A miss returns
// every field as zero.
// The datapath is a single pipeline that accepts one ray every cycle while
// in_stall is low. Most of its depth is the bit-per-stage divider that forms
// t (48 stages), then the multiply, bounds check and the 17-stage u/v
// dividers.
// The whole pipeline holds while a result waits at the output with
// out_stall high; in_stall then goes high as well, so nothing is dropped.
// Bubbles travel through the pipeline as invalid stages.
// Configuration registers are written through cfg_we/cfg_index/cfg_data and
// must only change while no ray is in flight. Reset (rst, synchronous)
// empties the pipeline and restores the unit square at z = 0, material 0.
module ray_xy_rect_intersect (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [rxr_pkg::CFG_IW-1:0] cfg_index,
  input  logic [rxr_pkg::CW-1:0]     cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [31:0]         origin_x,
  input  logic signed [31:0]         origin_y,
  input  logic signed [31:0]         origin_z,
  input  logic signed [31:0]         dir_x,
  input  logic signed [31:0]         dir_y,
  input  logic signed [31:0]         dir_z,
  input  logic signed [31:0]         t_min,
  input  logic signed [31:0]         t_max,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       hit_found,
  output logic signed [31:0]         t_hit,
  output logic signed [31:0]         point_x,
  output logic signed [31:0]         point_y,
  output logic signed [31:0]         point_z,
  output logic [16:0]                coord_u,
  output logic [16:0]                coord_v,
  output logic                       normal_positive,
  output logic [7:0]                 hit_material
);

  localparam int CW = rxr_pkg::CW;
  localparam int DIV_W = rxr_pkg::DIV_W;
  localparam int PX_W = rxr_pkg::PX_W;
  localparam int UV_LAT = rxr_pkg::UV_LAT;

  logic signed [CW-1:0] x_low, x_high, y_low, y_high, plane_z;
  logic [7:0]           material_tag;
  logic                 adv;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      x_low        <= '0;
      x_high       <= CW'(1) << rxr_pkg::FRAC_BITS;
      y_low        <= '0;
      y_high       <= CW'(1) << rxr_pkg::FRAC_BITS;
      plane_z      <= '0;
      material_tag <= '0;
    end else if (cfg_we) begin
      case (rxr_pkg::cfg_reg_t'(cfg_index))
        rxr_pkg::REG_X_LOW:    x_low        <= cfg_data;
        rxr_pkg::REG_X_HIGH:   x_high       <= cfg_data;
        rxr_pkg::REG_Y_LOW:    y_low        <= cfg_data;
        rxr_pkg::REG_Y_HIGH:   y_high       <= cfg_data;
        rxr_pkg::REG_PLANE_Z:  plane_z      <= cfg_data;
        rxr_pkg::REG_MATERIAL: material_tag <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // Stage A: distance to the plane.
  logic                 a_vld;
  rxr_pkg::ray_side_t   a_side;
  logic signed [CW:0]   a_diff;
  logic signed [CW:0]   a_diff_next;
  logic signed [CW-1:0] a_dz;

  assign a_diff_next = {plane_z[CW-1], plane_z} - {origin_z[CW-1], origin_z};

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (adv) begin
      a_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_side.ox    <= origin_x;
      a_side.oy    <= origin_y;
      a_side.dx    <= dir_x;
      a_side.dy    <= dir_y;
      a_side.tmin  <= t_min;
      a_side.tmax  <= t_max;
      a_side.dzneg <= dir_z[CW-1];
      a_side.neg   <= a_diff_next[CW] ^ dir_z[CW-1];
      a_side.zero  <= (dir_z == 0);
      a_diff       <= a_diff_next;
      a_dz         <= dir_z;
    end
  end

  // Divider pipeline: index 0 holds the magnitudes, each later index one
  // more quotient bit.
  logic                 dv_vld  [0:DIV_W];
  rxr_pkg::ray_side_t   dv_side [0:DIV_W];
  logic [CW-1:0]        dv_rem  [0:DIV_W];
  logic [DIV_W-1:0]     dv_n    [0:DIV_W];
  logic [DIV_W-1:0]     dv_q    [0:DIV_W];
  logic [CW-1:0]        dv_d    [0:DIV_W];
  logic [CW:0]          a_mag;
  logic [CW-1:0]        a_dmag;

  assign a_mag  = a_diff[CW] ? (CW+1)'(-a_diff) : a_diff;
  assign a_dmag = a_dz[CW-1] ? CW'(-a_dz) : a_dz;

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_vld[0] <= 1'b0;
    end else if (adv) begin
      dv_vld[0] <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_side[0]     <= a_side;
      dv_rem[0]      <= '0;
      dv_n[0]        <= {a_mag[CW-1:0], {rxr_pkg::FRAC_BITS{1'b0}}};
      dv_q[0]        <= '0;
      dv_d[0]        <= a_dmag;
    end
  end

  for (genvar k = 0; k < DIV_W; k++) begin : g_div
    logic [CW:0] r2;
    logic [CW:0] rs;
    logic        ge;
    assign r2 = {dv_rem[k], dv_n[k][DIV_W-1]};
    assign ge = r2 >= {1'b0, dv_d[k]};
    assign rs = r2 - {1'b0, dv_d[k]};
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[k+1] <= 1'b0;
      end else if (adv) begin
        dv_vld[k+1] <= dv_vld[k];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_side[k+1] <= dv_side[k];
        dv_rem[k+1]  <= ge ? rs[CW-1:0] : r2[CW-1:0];
        dv_n[k+1]    <= {dv_n[k][DIV_W-2:0], 1'b0};
        dv_q[k+1]    <= {dv_q[k][DIV_W-2:0], ge};
        dv_d[k+1]    <= dv_d[k];
      end
    end
  end

  // Sign the quotient, then test it against the interval.
  logic                  t1_vld, t2_vld;
  rxr_pkg::ray_side_t    t1_side, t2_side;
  logic signed [DIV_W:0] t1_t;
  logic signed [CW-1:0]  t2_t;
  logic                  t2_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      t1_vld <= 1'b0;
      t2_vld <= 1'b0;
    end else if (adv) begin
      t1_vld <= dv_vld[DIV_W];
      t2_vld <= t1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t1_side <= dv_side[DIV_W];
      t1_t    <= dv_side[DIV_W].neg ? (DIV_W+1)'(-{1'b0, dv_q[DIV_W]})
                                    : {1'b0, dv_q[DIV_W]};
      t2_side <= t1_side;
      t2_t    <= t1_t[CW-1:0];
      t2_ok   <= !t1_side.zero
                 && (t1_t >= (DIV_W+1)'(t1_side.tmin))
                 && (t1_t <= (DIV_W+1)'(t1_side.tmax));
    end
  end

  // Products of t with the x and y directions.
  logic                   m_vld;
  rxr_pkg::ray_side_t     m_side;
  logic signed [CW-1:0]   m_t;
  logic                   m_ok;
  logic signed [2*CW-1:0] m_px, m_py;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
    end else if (adv) begin
      m_vld <= t2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_side <= t2_side;
      m_t    <= t2_t;
      m_ok   <= t2_ok;
      m_px   <= t2_t * t2_side.dx;
      m_py   <= t2_t * t2_side.dy;
    end
  end

  // Hit point at full precision; the arithmetic shift floors.
  logic                   p_vld;
  logic                   p_ok, p_dzneg;
  logic signed [CW-1:0]   p_t;
  logic signed [PX_W-1:0] p_x, p_y;
  logic signed [2*CW-1:0] sh_x, sh_y;

  assign sh_x = m_px >>> rxr_pkg::FRAC_BITS;
  assign sh_y = m_py >>> rxr_pkg::FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else if (adv) begin
      p_vld <= m_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_ok    <= m_ok;
      p_dzneg <= m_side.dzneg;
      p_t     <= m_t;
      p_x     <= PX_W'(m_side.ox) + sh_x[PX_W-1:0];
      p_y     <= PX_W'(m_side.oy) + sh_y[PX_W-1:0];
    end
  end

  // Bounds check, and numerators and spans for u and v.
  logic                 uv_vld  [0:UV_LAT];
  rxr_pkg::uv_side_t    uv_side [0:UV_LAT];
  logic signed [CW:0]   c_nu, c_du, c_nv, c_dv;
  logic                 in_rect;

  assign in_rect = (p_x >= PX_W'(x_low)) && (p_x <= PX_W'(x_high))
                   && (p_y >= PX_W'(y_low)) && (p_y <= PX_W'(y_high));

  always_ff @(posedge clk) begin
    if (rst) begin
      uv_vld[0] <= 1'b0;
    end else if (adv) begin
      uv_vld[0] <= p_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      uv_side[0].hit   <= p_ok && in_rect;
      uv_side[0].dzneg <= p_dzneg;
      uv_side[0].t     <= p_t;
      uv_side[0].px    <= p_x[CW-1:0];
      uv_side[0].py    <= p_y[CW-1:0];
      c_nu <= {p_x[CW-1], p_x[CW-1:0]} - {x_low[CW-1], x_low};
      c_du <= {x_high[CW-1], x_high} - {x_low[CW-1], x_low};
      c_nv <= {p_y[CW-1], p_y[CW-1:0]} - {y_low[CW-1], y_low};
      c_dv <= {y_high[CW-1], y_high} - {y_low[CW-1], y_low};
    end
  end

  for (genvar k = 0; k < UV_LAT; k++) begin : g_uvside
    always_ff @(posedge clk) begin
      if (rst) begin
        uv_vld[k+1] <= 1'b0;
      end else if (adv) begin
        uv_vld[k+1] <= uv_vld[k];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        uv_side[k+1] <= uv_side[k];
      end
    end
  end

  logic [rxr_pkg::UVQ_W-1:0] u_q, v_q;

  rxr_uvdiv u_udiv (
    .clk   (clk),
    .en    (adv),
    .num   (c_nu),
    .den   (c_du),
    .coord (u_q)
  );

  rxr_uvdiv u_vdiv (
    .clk   (clk),
    .en    (adv),
    .num   (c_nv),
    .den   (c_dv),
    .coord (v_q)
  );

  // Output register.
  logic f_hit;
  assign f_hit = uv_side[UV_LAT].hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= uv_vld[UV_LAT];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit_found       <= f_hit;
      t_hit           <= f_hit ? uv_side[UV_LAT].t : '0;
      point_x         <= f_hit ? uv_side[UV_LAT].px : '0;
      point_y         <= f_hit ? uv_side[UV_LAT].py : '0;
      point_z         <= f_hit ? plane_z : '0;
      coord_u         <= f_hit ? u_q : '0;
      coord_v         <= f_hit ? v_q : '0;
      normal_positive <= f_hit && uv_side[UV_LAT].dzneg;
      hit_material    <= f_hit ? material_tag : '0;
    end
  end

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !hit_found) |-> (t_hit == 0 && point_x == 0 && point_y == 0
      && coord_u == 0 && coord_v == 0 && !normal_positive))
    else $error("miss result carries nonzero fields");

  a_uv_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (coord_u <= 17'h10000 && coord_v <= 17'h10000))
    else $error("u or v beyond one");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(t_hit)
      && $stable(uv_vld[UV_LAT])))
    else $error("pipeline moved under a stalled result");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> in_stall)
    else $error("input taken while output stalled");

endmodule

FILE: rtl/core/rxr_uvdiv.sv
module rxr_uvdiv (
  input  logic                   clk,
  input  logic                   en,
  input  logic signed [rxr_pkg::CW:0] num,
  input  logic signed [rxr_pkg::CW:0] den,
  output logic [rxr_pkg::UVQ_W-1:0]   coord
);

  logic [rxr_pkg::CW:0]      rem  [0:rxr_pkg::UVQ_W];
  logic [rxr_pkg::UVQ_W-1:0] quo  [0:rxr_pkg::UVQ_W];
  logic [rxr_pkg::CW-1:0]    dv   [0:rxr_pkg::UVQ_W];
  logic                      zero [0:rxr_pkg::UVQ_W];

  // On a hit the numerator never exceeds the denominator, so the quotient
  // stays within one and the remainder fits the divisor width.
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= {1'b0, num[rxr_pkg::CW-1:0]};
      quo[0]  <= '0;
      dv[0]   <= den[rxr_pkg::CW-1:0];
      zero[0] <= (den <= 0) || (num <= 0);
    end
  end

  for (genvar j = 0; j < rxr_pkg::UVQ_W; j++) begin : g_step
    logic                   ge;
    logic [rxr_pkg::CW:0]   rr;
    assign ge = rem[j] >= {1'b0, dv[j]};
    assign rr = ge ? (rem[j] - {1'b0, dv[j]}) : rem[j];
    always_ff @(posedge clk) begin
      if (en) begin
        rem[j+1]  <= {rr[rxr_pkg::CW-1:0], 1'b0};
        quo[j+1]  <= {quo[j][rxr_pkg::UVQ_W-2:0], ge};
        dv[j+1]   <= dv[j];
        zero[j+1] <= zero[j];
      end
    end
  end

  assign coord = zero[rxr_pkg::UVQ_W] ? '0 : quo[rxr_pkg::UVQ_W];

endmodule
